[rtl/core/cns_pkg.sv]
// Package for the nearest-center search block: field widths, register
// indexes, request codes, default sizes and the datapath control struct.
// No dependencies.
package cns_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_CENTERS = 256;
    localparam int DEF_MAX_DIMS    = 16;
    localparam int DEF_COORD_BITS  = 16;

    // Fixed field widths of the transactions and registers.
    localparam int CENTER_IDX_W  = 8;
    localparam int COORD_IDX_W   = 4;
    localparam int NEAREST_W     = 8;
    localparam int CHECKED_W     = 9;
    localparam int NUM_CENTERS_W = 9;
    localparam int DIMS_W        = 5;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_IDX_W     = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 1'b1;

    // Register values after reset.
    localparam logic [NUM_CENTERS_W-1:0] RST_NUM_CENTERS = 9'd1;
    localparam logic [DIMS_W-1:0]        RST_DIMS_IN_USE = 5'd16;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Control that travels with each coordinate read through the datapath.
    typedef struct packed {
        logic valid;
        logic first_dim;
        logic last_dim;
        logic first_center;
        logic last_center;
    } t_dist_ctrl;

endpackage

[rtl/core/cns_req_if.sv]
// Request channel of the nearest-center search block: valid/ready plus the
// load or query coordinate payload. Depends on cns_pkg.
interface cns_req_if #(
    parameter int COORD_BITS = cns_pkg::DEF_COORD_BITS
);
    import cns_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [CENTER_IDX_W-1:0]        center_index;
    logic [COORD_IDX_W-1:0]         coord_index;
    logic signed [COORD_BITS-1:0]   coord_value;
    logic                           query_last;

    modport source (
        output valid, req_type, center_index, coord_index, coord_value, query_last,
        input  ready
    );

    modport sink (
        input  valid, req_type, center_index, coord_index, coord_value, query_last,
        output ready
    );

endinterface

[rtl/core/cns_res_if.sv]
// Result channel of the nearest-center search block: valid/ready plus the
// nearest index and the number of centers checked. Depends on cns_pkg.
interface cns_res_if;
    import cns_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [NEAREST_W-1:0]   nearest_index;
    logic [CHECKED_W-1:0]   centers_checked;

    modport source (
        output valid, nearest_index, centers_checked,
        input  ready
    );

    modport sink (
        input  valid, nearest_index, centers_checked,
        output ready
    );

endinterface

[rtl/core/cns_store.sv]
// Center store and query buffer memories, one write and one registered
// read port each. Depends on cns_pkg only through its parameter defaults.
module cns_store #(
    parameter int MAX_CENTERS = cns_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = cns_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = cns_pkg::DEF_COORD_BITS,
    parameter int ADDR_W      = $clog2(MAX_CENTERS * MAX_DIMS),
    parameter int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_wr_center,
    input  logic                         i_wr_query,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [DIM_W-1:0]             i_wr_dim,
    input  logic signed [COORD_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    input  logic [DIM_W-1:0]             i_rd_dim,
    output logic signed [COORD_BITS-1:0] o_center_data,
    output logic signed [COORD_BITS-1:0] o_query_data
);
    import cns_pkg::*;

    localparam int STORE_DEPTH = MAX_CENTERS * MAX_DIMS;

    logic signed [COORD_BITS-1:0] r_center_mem [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] r_query_mem  [MAX_DIMS];

    always_ff @(posedge i_clk) begin
        if (i_wr_center) begin
            r_center_mem[i_wr_addr] <= i_wr_data;
        end
        o_center_data <= r_center_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_query) begin
            r_query_mem[i_wr_dim] <= i_wr_data;
        end
        o_query_data <= r_query_mem[i_rd_dim];
    end

endmodule

[rtl/core/cns_dist.sv]
// Shared distance unit: absolute difference, square, saturating accumulate
// and running minimum with its center index. Depends on cns_pkg.
module cns_dist #(
    parameter int MAX_DIMS   = cns_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS = cns_pkg::DEF_COORD_BITS,
    parameter int CI_W       = $clog2(cns_pkg::DEF_MAX_CENTERS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cns_pkg::t_dist_ctrl          i_ctrl,
    input  logic [CI_W-1:0]              i_center,
    input  logic signed [COORD_BITS-1:0] i_center_data,
    input  logic signed [COORD_BITS-1:0] i_query_data,
    output logic                         o_done,
    output logic [CI_W-1:0]              o_best_index
);
    import cns_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int RAW_W  = SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
    localparam int ACC_W  = (RAW_W > 64) ? 64 : RAW_W;

    t_dist_ctrl                  r_ctrl_a, r_ctrl_b, r_ctrl_c;
    logic [CI_W-1:0]             r_cen_a, r_cen_b, r_cen_c;
    logic [COORD_BITS-1:0]       r_diff;
    logic [SQ_W-1:0]             r_sq;
    logic [ACC_W-1:0]            r_acc;
    logic [ACC_W-1:0]            r_best;

    logic signed [COORD_BITS:0]  w_diff;
    logic [COORD_BITS:0]         w_abs;
    logic [ACC_W:0]              w_sum_raw;
    logic [ACC_W-1:0]            w_sum;
    logic                        w_take;

    // The magnitude of a difference of two coordinates always fits COORD_BITS.
    assign w_diff = (COORD_BITS + 1)'(i_center_data) - (COORD_BITS + 1)'(i_query_data);
    assign w_abs  = w_diff[COORD_BITS] ? (COORD_BITS + 1)'(-w_diff) : w_diff;

    assign w_sum_raw = (ACC_W + 1)'(r_ctrl_c.first_dim ? '0 : r_acc) + (ACC_W + 1)'(r_sq);
    assign w_sum     = w_sum_raw[ACC_W] ? '1 : w_sum_raw[ACC_W-1:0];
    assign w_take    = r_ctrl_c.first_center || (w_sum < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
            r_ctrl_b <= '0;
            r_ctrl_c <= '0;
            o_done   <= 1'b0;
        end else begin
            r_ctrl_a <= i_ctrl;
            r_ctrl_b <= r_ctrl_a;
            r_ctrl_c <= r_ctrl_b;
            o_done   <= r_ctrl_c.valid && r_ctrl_c.last_dim && r_ctrl_c.last_center;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cen_a <= i_center;
        r_cen_b <= r_cen_a;
        r_cen_c <= r_cen_b;
        r_diff  <= w_abs[COORD_BITS-1:0];
        r_sq    <= SQ_W'(r_diff) * SQ_W'(r_diff);
        if (r_ctrl_c.valid) begin
            r_acc <= w_sum;
            if (r_ctrl_c.last_dim && w_take) begin
                r_best       <= w_sum;
                o_best_index <= r_cen_c;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A new center always begins with its first coordinate.
    a_center_starts_at_dim0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl_c.valid && r_ctrl_c.last_dim && !r_ctrl_c.last_center)
            |=> (!r_ctrl_c.valid || r_ctrl_c.first_dim))
        else $error("center did not restart at its first coordinate");

    // The search result is reported in the cycle after the final coordinate.
    a_done_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_ctrl_c.valid && r_ctrl_c.last_dim && r_ctrl_c.last_center))
        else $error("done raised without a final coordinate");

    // The pipeline carries one search at a time: nothing follows the final
    // coordinate right away.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl_c.valid && r_ctrl_c.last_dim && r_ctrl_c.last_center) |=> !r_ctrl_c.valid)
        else $error("coordinates overlap the end of a search");
`endif

endmodule

[rtl/core/nearest_center_search_top.sv]
// Top level of the nearest-center search block: configuration registers,
// search sequencer and result register. Depends on cns_pkg, cns_req_if,
// cns_res_if, cns_store and cns_dist.

// Brute-force nearest-center search over squared Euclidean distance. A load
// transaction writes one coordinate of one center into the center store; a
// query transaction writes one coordinate into the query buffer, and the query
// transaction flagged last starts a search. A search walks every center in
// use and every dimension in use through one shared subtract, square and
// accumulate unit, one coordinate pair per cycle, fed by a single read port
// of the center store, and then drains the pipeline. The request channel is
// not ready while a search runs. The result, the lowest index among the
// centers at the smallest distance and the number of centers compared, sits
// in an output register; loads are taken while it waits, and a following
// search starts only once the register has been emptied. Out-of-range
// register values are clamped when a search starts, loads and query
// coordinates beyond the store are dropped, and configuration writes are
// meant for an idle block. Reading a center or query coordinate that was
// never written gives an undefined result; the stores have no reset and no
// clearing pass.
module nearest_center_search_top #(
    parameter int MAX_CENTERS = cns_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = cns_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = cns_pkg::DEF_COORD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    cns_req_if.sink                          i_req,
    cns_res_if.source                        o_res
);
    import cns_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CENTERS * MAX_DIMS);
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DCNT_W = $clog2(MAX_DIMS + 1);
    localparam int CI_W   = $clog2(MAX_CENTERS);
    localparam int CNT_W  = ($clog2(MAX_CENTERS + 1) > CHECKED_W) ?
                            $clog2(MAX_CENTERS + 1) : CHECKED_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                     r_state;
    logic [NUM_CENTERS_W-1:0]   r_num_centers;
    logic [DIMS_W-1:0]          r_dims_in_use;
    logic [CNT_W-1:0]           r_k;
    logic [DCNT_W-1:0]          r_dims;
    logic [CI_W-1:0]            r_cen;
    logic [DIM_W-1:0]           r_dim;
    logic [ADDR_W-1:0]          r_base;
    logic                       r_out_valid;
    logic [NEAREST_W-1:0]       r_out_index;
    logic [CHECKED_W-1:0]       r_out_count;

    logic                       w_accept;
    logic                       w_load_ok;
    logic                       w_query_ok;
    logic                       w_start;
    logic [CNT_W-1:0]           w_k_eff;
    logic [DCNT_W-1:0]          w_dims_eff;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic [ADDR_W-1:0]          w_rd_addr;
    logic                       w_last_dim;
    logic                       w_last_center;
    t_dist_ctrl                 w_ctrl;
    logic signed [COORD_BITS-1:0] w_center_data;
    logic signed [COORD_BITS-1:0] w_query_data;
    logic                       w_done;
    logic [CI_W-1:0]            w_best_index;

    // Requests are taken only while no search is pending or running.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Coordinates outside the store are dropped; a last query still searches.
    assign w_load_ok  = w_accept && (i_req.req_type == REQ_LOAD)
                        && (32'(i_req.center_index) < MAX_CENTERS)
                        && (32'(i_req.coord_index) < MAX_DIMS);
    assign w_query_ok = w_accept && (i_req.req_type == REQ_QUERY)
                        && (32'(i_req.coord_index) < MAX_DIMS);
    assign w_start    = w_accept && (i_req.req_type == REQ_QUERY) && i_req.query_last;

    assign w_wr_addr = ADDR_W'(32'(i_req.center_index) * MAX_DIMS + 32'(i_req.coord_index));

    // Register values are clamped into the supported range when a search starts.
    always_comb begin
        if (r_num_centers == '0) begin
            w_k_eff = CNT_W'(1);
        end else if (32'(r_num_centers) > MAX_CENTERS) begin
            w_k_eff = CNT_W'(MAX_CENTERS);
        end else begin
            w_k_eff = CNT_W'(r_num_centers);
        end
        if (r_dims_in_use == '0) begin
            w_dims_eff = DCNT_W'(1);
        end else if (32'(r_dims_in_use) > MAX_DIMS) begin
            w_dims_eff = DCNT_W'(MAX_DIMS);
        end else begin
            w_dims_eff = DCNT_W'(r_dims_in_use);
        end
    end

    // Center c, dimension d sits at c * MAX_DIMS + d; the base steps per center.
    assign w_rd_addr     = r_base + ADDR_W'(r_dim);
    assign w_last_dim    = (DCNT_W'(r_dim) == r_dims - DCNT_W'(1));
    assign w_last_center = (CNT_W'(r_cen) == r_k - CNT_W'(1));

    always_comb begin
        w_ctrl.valid        = (r_state == S_RUN);
        w_ctrl.first_dim    = (r_dim == '0);
        w_ctrl.last_dim     = w_last_dim;
        w_ctrl.first_center = (r_cen == '0);
        w_ctrl.last_center  = w_last_center;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_centers <= RST_NUM_CENTERS;
            r_dims_in_use <= RST_DIMS_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_CENTERS: r_num_centers <= i_cfg_data[NUM_CENTERS_W-1:0];
                CFG_DIMS_IN_USE: r_dims_in_use <= i_cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cen       <= '0;
            r_dim       <= '0;
            r_base      <= '0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_k     <= w_k_eff;
                        r_dims  <= w_dims_eff;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // Start only with an empty result register, so the
                    // finished search always finds room.
                    if (!r_out_valid) begin
                        r_cen   <= '0;
                        r_dim   <= '0;
                        r_base  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last_dim) begin
                        r_dim  <= '0;
                        r_base <= r_base + ADDR_W'(MAX_DIMS);
                        r_cen  <= r_cen + CI_W'(1);
                        if (w_last_center) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_dim <= r_dim + DIM_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (w_done) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= NEAREST_W'(w_best_index);
                        r_out_count <= CHECKED_W'(r_k);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.nearest_index   = r_out_index;
    assign o_res.centers_checked = r_out_count;

    cns_store #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_BITS  (COORD_BITS),
        .ADDR_W      (ADDR_W),
        .DIM_W       (DIM_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_center   (w_load_ok),
        .i_wr_query    (w_query_ok),
        .i_wr_addr     (w_wr_addr),
        .i_wr_dim      (DIM_W'(i_req.coord_index)),
        .i_wr_data     (i_req.coord_value),
        .i_rd_addr     (w_rd_addr),
        .i_rd_dim      (r_dim),
        .o_center_data (w_center_data),
        .o_query_data  (w_query_data)
    );

    cns_dist #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS),
        .CI_W       (CI_W)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_center      (r_cen),
        .i_center_data (w_center_data),
        .i_query_data  (w_query_data),
        .o_done        (w_done),
        .o_best_index  (w_best_index)
    );

`ifndef NO_ASSERTIONS
    // A finished search never overwrites a result that is still waiting.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_out_valid)
        else $error("search finished while the result register was full");

    // The distance unit reports only after the sequencer has issued everything.
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DRAIN))
        else $error("search finished outside the drain phase");

    // The center counter stays inside the centers in use while issuing.
    a_center_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (CNT_W'(r_cen) < r_k))
        else $error("center counter ran past the centers in use");

    // The last query transaction always leads into a search.
    a_last_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_WAIT))
        else $error("last query transaction did not start a search");
`endif

endmodule
